FILE: hdl/ttcw_pkg.sv
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared sizes, constants and types for the text terminal cell writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Index widths inside the block
  localparam int ADDR_W    = $clog2(CELL_COUNT);
  localparam int COL_IDX_W = $clog2(COLUMNS);
  localparam int ROW_IDX_W = $clog2(ROWS);

  // Port field widths
  localparam int KIND_W    = 1;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int CELL_W    = CHAR_W + COLOR_W;
  localparam int INDEX_W   = 11;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PUT  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

  // Cell contents
  localparam logic [CHAR_W-1:0]  SPACE_CHAR  = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd79;
  localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, SPACE_CHAR};

  // Addresses used by the cursor and the scroll sweep
  localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_CNT      = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);

  localparam logic [COL_IDX_W-1:0] LAST_COL = COL_IDX_W'(COLUMNS - 1);
  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(ROWS - 1);

  // Cursor position, linear cell address and scroll flag
  typedef struct packed {
    logic [COL_IDX_W-1:0] col;
    logic [ROW_IDX_W-1:0] row;
    logic [ADDR_W-1:0]    pos;
    logic                 scroll;
  } cursor_t;

endpackage

`default_nettype wire

FILE: hdl/ttcw_ram.sv
// ----------------------------------------------------------------------------
// ttcw_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 2000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/ttcw_cursor.sv
// ----------------------------------------------------------------------------
// ttcw_cursor
// Cursor tracker: column, row and linear cell address, with wrap at the
// end of a line and scroll detection past the last row.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_cursor (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  output ttcw_pkg::cursor_t      cur,
  output ttcw_pkg::cursor_t      nxt
);

  import ttcw_pkg::*;

  logic [COL_IDX_W-1:0] col_r;
  logic [ROW_IDX_W-1:0] row_r;
  logic [ADDR_W-1:0]    pos_r;

  // Position after one put
  always_comb begin
    nxt.col    = col_r + 1'b1;
    nxt.row    = row_r;
    nxt.pos    = pos_r + 1'b1;
    nxt.scroll = 1'b0;
    if (col_r == LAST_COL) begin
      nxt.col = '0;
      if (row_r == LAST_ROW) begin
        // past the last row: stay on it, screen scrolls
        nxt.pos    = LAST_ROW_BASE;
        nxt.scroll = 1'b1;
      end else begin
        nxt.row = row_r + 1'b1;
      end
    end
  end

  assign cur.col    = col_r;
  assign cur.row    = row_r;
  assign cur.pos    = pos_r;
  assign cur.scroll = 1'b0;

  // Cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else if (advance) begin
      col_r <= nxt.col;
      row_r <= nxt.row;
      pos_r <= nxt.pos;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/text_terminal_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_writer_unit
// 80 x 25 character-cell screen store with cursor, wrap and scroll.
// ----------------------------------------------------------------------------
// After reset the block clears the screen store to spaces in the reset
// color, one cell per cycle, before the first item is accepted; color
// writes are taken at any time. A put item writes its cell in the cycle
// it is accepted and its result is registered for the following cycle, so
// puts run at one item per cycle while the result port is not held and no
// scroll is under way. A read item passes through ST_READ, as the store's
// read port is registered. A put that scrolls delivers its result at once,
// then the store is swept once: each cell is read from one row below and
// written back, the bottom row is filled with spaces in the color current
// at that put; input items stall through ST_SCROLL and ST_TAIL. The single
// store port pair bounds all of this. An out-of-range read returns zero.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cell_writer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input items
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ttcw_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [ttcw_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic [ttcw_pkg::INDEX_W-1:0]    in_cell_index,
  // results
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [ttcw_pkg::CELL_W-1:0]     out_cell_value,
  output logic      [ttcw_pkg::OUT_COL_W-1:0]  out_cursor_col,
  output logic      [ttcw_pkg::OUT_ROW_W-1:0]  out_cursor_row,
  output logic                                 out_scrolled,
  // color register
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ttcw_pkg::COLOR_W-1:0]    cfg_text_color
);

  import ttcw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_TAIL
  } state_t;

  state_t state_r;

  logic [COLOR_W-1:0] color_r;
  logic [COLOR_W-1:0] blank_r;
  logic [ADDR_W-1:0]  sweep_r;
  logic               wv_r;
  logic [ADDR_W-1:0]  wa_r;
  logic               wcopy_r;
  logic               oor_r;

  logic                 out_valid_r;
  logic [CELL_W-1:0]    out_value_r;
  logic [COL_IDX_W-1:0] out_col_r;
  logic [ROW_IDX_W-1:0] out_row_r;
  logic                 out_scrolled_r;

  logic               in_xfer;
  logic               put_xfer;
  logic               out_load;
  logic               idx_ok;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;
  cursor_t            cur;
  cursor_t            cur_nxt;

  // Handshakes
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign put_xfer  = in_xfer && (in_kind == KIND_PUT);
  assign cfg_ready = 1'b1;
  assign idx_ok    = (32'(in_cell_index) < CELL_COUNT);

  // A result is loaded by a put transfer or at the end of a read
  assign out_load  = put_xfer || (state_r == ST_READ);

  // Color register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= RESET_COLOR;
    end else if (cfg_valid) begin
      color_r <= cfg_text_color;
    end
  end

  ttcw_cursor u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (put_xfer),
    .cur     (cur),
    .nxt     (cur_nxt)
  );

  // Store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_r;
    ram_wdata = RESET_CELL;
    ram_raddr = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_we    = put_xfer;
        ram_waddr = cur.pos;
        ram_wdata = {color_r, in_char_code};
        if (idx_ok) begin
          ram_raddr = ADDR_W'(in_cell_index);
        end
      end
      ST_SCROLL, ST_TAIL: begin
        // write stage trails the read stage by one cell
        ram_we    = wv_r;
        ram_waddr = wa_r;
        ram_wdata = wcopy_r ? ram_rdata : {blank_r, SPACE_CHAR};
        if (sweep_r < COPY_CNT) begin
          ram_raddr = sweep_r + ROW_STRIDE;
        end
      end
      ST_READ: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ttcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (sweep_r == LAST_CELL) begin
            sweep_r <= '0;
            state_r <= ST_IDLE;
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_kind == KIND_PUT) begin
              out_value_r    <= {color_r, in_char_code};
              out_col_r      <= cur_nxt.col;
              out_row_r      <= cur_nxt.row;
              out_scrolled_r <= cur_nxt.scroll;
              if (cur_nxt.scroll) begin
                blank_r <= color_r;
                sweep_r <= '0;
                state_r <= ST_SCROLL;
              end
            end else begin
              oor_r   <= !idx_ok;
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          out_value_r    <= oor_r ? '0 : ram_rdata;
          out_col_r      <= cur.col;
          out_row_r      <= cur.row;
          out_scrolled_r <= 1'b0;
          state_r        <= ST_IDLE;
        end
        ST_SCROLL: begin
          wv_r    <= 1'b1;
          wa_r    <= sweep_r;
          wcopy_r <= (sweep_r < COPY_CNT);
          if (sweep_r == LAST_CELL) begin
            state_r <= ST_TAIL;
          end else begin
            sweep_r <= sweep_r + 1'b1;
          end
        end
        ST_TAIL: begin
          // last bottom-row cell written this cycle
          wv_r    <= 1'b0;
          sweep_r <= '0;
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result ports
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_cursor_col = OUT_COL_W'(out_col_r);
  assign out_cursor_row = OUT_ROW_W'(out_row_r);
  assign out_scrolled   = out_scrolled_r;

endmodule

`default_nettype wire
